>>> hw/rtl/prmiq_pkg.sv
package prmiq_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int PAGE_BITS   = 12;
	localparam int ADDR_W      = 32;
	localparam int PN_W        = ADDR_W - PAGE_BITS;
	localparam int PAGE_W      = PN_W + 1;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 3);

	localparam logic [PAGE_W-1:0] PAGE_COUNT = PAGE_W'(1) << PN_W;

	// Item modes and result status codes
	localparam logic MODE_MAP    = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;
	localparam logic STATUS_FULL = 1'b1;

	// Push slots examined for one source region during a map walk
	localparam logic [1:0] SLOT_LEAD  = 2'd0;
	localparam logic [1:0] SLOT_MID   = 2'd1;
	localparam logic [1:0] SLOT_TRAIL = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] length_bytes;
		logic [2:0]        permission;
		logic [7:0]        region_state;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic [20:0]       start_page;
		logic [20:0]       end_page;
		logic [2:0]        found_permission;
		logic [7:0]        found_state;
		logic [ADDR_W-1:0] mapped_bytes;
	} out_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] first;
		logic [PAGE_W-1:0] last;
		logic [2:0]        perm;
		logic [7:0]        code;
	} region_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_QWALK  = 6'b000010,
		ST_MWALK  = 6'b000100,
		ST_MTAIL  = 6'b001000,
		ST_MFLUSH = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

endpackage

>>> hw/rtl/page_region_map_insert_query.sv
// Page region table with map and query items.
// Input channel in_valid/in_stall/in_data: one transfer per item. A map item
// (mode 0) overwrites a page range and merges equal neighbors; a query item
// (mode 1) looks up the region holding an address. Output channel
// out_valid/out_stall/out_data: exactly one result transfer per item, in order.
// cfg_write_en/cfg_write_data set the free state code; write only when idle.
// Flow: one item at a time. A query walks the table from entry 0 until it
// hits or reaches the last region. A map walks every region once, then a
// tail, a flush and a result state; a full table holds 64 regions. The walk
// is bound by the single read port of the table bank: one region per cycle,
// but a map stays on a region while it still has split pieces to push.
// A zero-length map skips the walk and goes straight to the result state.
// The table is two banks: a map reads the live bank and writes the rebuilt
// table into the other, then swaps banks on success or drops it when full.
// Reset: one region covering all pages, permission 0, free state code, byte
// total zero; no clearing pass, the initial region is supplied by logic.
// A stalled result holds in the output register; the next input transfer is
// taken meanwhile, and the block waits only when a second result is ready.
module page_region_map_insert_query (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  prmiq_pkg::in_item_t    in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output prmiq_pkg::out_item_t   out_data,
	input  logic                   cfg_write_en,
	input  logic [7:0]             cfg_write_data
);

	localparam int PW  = prmiq_pkg::PAGE_W;
	localparam int IW  = prmiq_pkg::IDX_W;
	localparam int CW  = prmiq_pkg::CNT_W;
	localparam int PB  = prmiq_pkg::PAGE_BITS;
	localparam int AW  = prmiq_pkg::ADDR_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(prmiq_pkg::MAX_REGIONS);

	// Control state
	prmiq_pkg::state_t state_q, state_d;
	logic              out_v_q, out_v_d;
	logic              bank_q, bank_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     byte_total_q, byte_total_d;
	logic              pristine_q, pristine_d;
	logic [7:0]        free_code_q;
	logic              placed_q, placed_d;
	logic              pend_v_q, pend_v_d;
	logic [CW-1:0]     m_q, m_d;
	logic [IW-1:0]     i_q, i_d;
	logic [1:0]        ph_q, ph_d;

	// Payload registers
	prmiq_pkg::out_item_t out_q, out_d;
	prmiq_pkg::out_item_t res_q, res_d;
	prmiq_pkg::region_t   pend_q, pend_d;
	logic [PW-1:0]        s_q, s_d, e_q, e_d, np_q, np_d;
	logic [2:0]           perm_q, perm_d;
	logic [7:0]           code_q, code_d;

	// Table banks
	prmiq_pkg::region_t mem0 [prmiq_pkg::MAX_REGIONS];
	prmiq_pkg::region_t mem1 [prmiq_pkg::MAX_REGIONS];
	prmiq_pkg::region_t rd0_q, rd1_q;
	logic [IW-1:0]      rd_addr, wr_addr;
	logic               wr_en;
	prmiq_pkg::region_t wr_data;

	// Walk datapath
	prmiq_pkg::region_t r, new_item, item0, item1, item2, push_item;
	logic               in_acc, out_free, last_entry, hit;
	logic               nonov, need0, need1, need2, take0, take1, take2, more;
	logic               push, push_new, can_merge;
	logic [PW-1:0]      in_page, in_np;
	logic [PW:0]        e_sum;
	logic [AW:0]        np_bytes;
	logic [AW-1:0]      byte_sum;

	assign in_stall  = (state_q != prmiq_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign out_free  = !out_v_q || !out_stall;

	// Before the first map the table is the single all-pages region
	always_comb begin
		if (pristine_q) begin
			r.first = '0;
			r.last  = prmiq_pkg::PAGE_COUNT;
			r.perm  = '0;
			r.code  = free_code_q;
		end else begin
			r = bank_q ? rd1_q : rd0_q;
		end
	end

	assign last_entry = ((CW'(i_q) + CW'(1)) >= count_q);
	assign hit        = (r.first <= s_q) && (s_q < r.last);

	// Rounding of the incoming range
	assign in_page = PW'(in_data.address[AW-1:PB]);
	assign in_np   = PW'(in_data.length_bytes[AW-1:PB])
	               + PW'(|in_data.length_bytes[PB-1:0]);
	assign e_sum   = (PW+1)'(in_page) + (PW+1)'(in_np);
	assign np_bytes = {np_q, {PB{1'b0}}};
	assign byte_sum = byte_total_q + np_bytes[AW-1:0];

	// Pieces a source region contributes, in table order
	assign new_item = '{first: s_q, last: e_q, perm: perm_q, code: code_q};
	assign nonov = (r.last <= s_q) || (r.first >= e_q);
	assign need0 = nonov ? ((r.first >= e_q) && !placed_q) : (r.first < s_q);
	assign need1 = nonov || !placed_q;
	assign need2 = !nonov && (r.last > e_q);
	assign item0 = nonov ? new_item
	             : prmiq_pkg::region_t'{first: r.first, last: s_q, perm: r.perm, code: r.code};
	assign item1 = nonov ? r : new_item;
	assign item2 = '{first: e_q, last: r.last, perm: r.perm, code: r.code};
	assign take0 = (ph_q == prmiq_pkg::SLOT_LEAD) && need0;
	assign take1 = !take0 && (ph_q != prmiq_pkg::SLOT_TRAIL) && need1;
	assign take2 = !take0 && !take1 && need2;
	assign more  = take0 ? (need1 || need2) : (take1 ? need2 : 1'b0);

	always_comb begin
		push      = 1'b0;
		push_new  = 1'b0;
		push_item = new_item;
		if (state_q == prmiq_pkg::ST_MWALK) begin
			push      = take0 || take1 || take2;
			push_new  = (take0 && nonov) || (take1 && !nonov);
			push_item = take0 ? item0 : (take1 ? item1 : item2);
		end else if (state_q == prmiq_pkg::ST_MTAIL) begin
			push     = !placed_q;
			push_new = !placed_q;
		end
	end

	assign can_merge = pend_v_q && (pend_q.perm == push_item.perm)
	                && (pend_q.code == push_item.code) && (pend_q.last == push_item.first);

	// Write the finished merged region into the spare bank
	always_comb begin
		wr_addr = m_q[IW-1:0];
		wr_data = pend_q;
		wr_en   = 1'b0;
		if (state_q == prmiq_pkg::ST_MFLUSH) begin
			wr_en = (m_q < MAX_CNT);
		end else if (push && !can_merge && pend_v_q) begin
			wr_en = (m_q < MAX_CNT);
		end
	end

	// Read address: stay on the region until all its pieces are pushed
	always_comb begin
		case (state_q)
			prmiq_pkg::ST_IDLE:  rd_addr = '0;
			prmiq_pkg::ST_QWALK: rd_addr = i_q + IW'(1);
			prmiq_pkg::ST_MWALK: rd_addr = more ? i_q : i_q + IW'(1);
			default:             rd_addr = i_q;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		out_v_d      = out_v_q;
		bank_d       = bank_q;
		count_d      = count_q;
		byte_total_d = byte_total_q;
		pristine_d   = pristine_q;
		placed_d     = placed_q;
		pend_v_d     = pend_v_q;
		m_d          = m_q;
		i_d          = i_q;
		ph_d         = ph_q;
		out_d        = out_q;
		res_d        = res_q;
		pend_d       = pend_q;
		s_d          = s_q;
		e_d          = e_q;
		np_d         = np_q;
		perm_d       = perm_q;
		code_d       = code_q;

		if (out_v_q && !out_stall) begin
			out_v_d = 1'b0;
		end

		// Merge stage: extend the held region or retire it
		if (push) begin
			if (push_new) begin
				placed_d = 1'b1;
			end
			if (can_merge) begin
				pend_d.last = push_item.last;
			end else begin
				if (pend_v_q) begin
					m_d = m_q + CW'(1);
				end
				pend_d   = push_item;
				pend_v_d = 1'b1;
			end
		end

		case (state_q)
			prmiq_pkg::ST_IDLE: begin
				if (in_acc) begin
					i_d   = '0;
					res_d = '0;
					if (in_data.mode == prmiq_pkg::MODE_QUERY) begin
						s_d     = in_page;
						state_d = prmiq_pkg::ST_QWALK;
					end else if (in_np == '0) begin
						res_d.mapped_bytes = byte_total_q;
						state_d            = prmiq_pkg::ST_RESULT;
					end else begin
						s_d      = in_page;
						e_d      = (e_sum > (PW+1)'(prmiq_pkg::PAGE_COUNT))
						         ? prmiq_pkg::PAGE_COUNT : e_sum[PW-1:0];
						np_d     = in_np;
						perm_d   = in_data.permission;
						code_d   = in_data.region_state;
						placed_d = 1'b0;
						pend_v_d = 1'b0;
						m_d      = '0;
						ph_d     = prmiq_pkg::SLOT_LEAD;
						state_d  = prmiq_pkg::ST_MWALK;
					end
				end
			end
			prmiq_pkg::ST_QWALK: begin
				if (hit || last_entry) begin
					res_d.mapped_bytes = byte_total_q;
					if (hit) begin
						res_d.start_page       = r.first;
						res_d.end_page         = r.last;
						res_d.found_permission = r.perm;
						res_d.found_state      = r.code;
					end
					state_d = prmiq_pkg::ST_RESULT;
				end else begin
					i_d = i_q + IW'(1);
				end
			end
			prmiq_pkg::ST_MWALK: begin
				if (more) begin
					ph_d = take0 ? prmiq_pkg::SLOT_MID : prmiq_pkg::SLOT_TRAIL;
				end else begin
					ph_d = prmiq_pkg::SLOT_LEAD;
					if (last_entry) begin
						state_d = prmiq_pkg::ST_MTAIL;
					end else begin
						i_d = i_q + IW'(1);
					end
				end
			end
			prmiq_pkg::ST_MTAIL: begin
				state_d = prmiq_pkg::ST_MFLUSH;
			end
			prmiq_pkg::ST_MFLUSH: begin
				// Commit the rebuilt bank unless it overflowed
				if (m_q >= MAX_CNT) begin
					res_d.status       = prmiq_pkg::STATUS_FULL;
					res_d.mapped_bytes = byte_total_q;
				end else begin
					bank_d             = !bank_q;
					count_d            = m_q + CW'(1);
					byte_total_d       = byte_sum;
					pristine_d         = 1'b0;
					res_d.mapped_bytes = byte_sum;
				end
				state_d = prmiq_pkg::ST_RESULT;
			end
			prmiq_pkg::ST_RESULT: begin
				if (out_free) begin
					out_d   = res_q;
					out_v_d = 1'b1;
					state_d = prmiq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prmiq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= prmiq_pkg::ST_IDLE;
			out_v_q      <= 1'b0;
			bank_q       <= 1'b0;
			count_q      <= CW'(1);
			byte_total_q <= '0;
			pristine_q   <= 1'b1;
			free_code_q  <= '0;
			placed_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			m_q          <= '0;
			i_q          <= '0;
			ph_q         <= prmiq_pkg::SLOT_LEAD;
		end else begin
			state_q      <= state_d;
			out_v_q      <= out_v_d;
			bank_q       <= bank_d;
			count_q      <= count_d;
			byte_total_q <= byte_total_d;
			pristine_q   <= pristine_d;
			placed_q     <= placed_d;
			pend_v_q     <= pend_v_d;
			m_q          <= m_d;
			i_q          <= i_d;
			ph_q         <= ph_d;
			if (cfg_write_en) begin
				free_code_q <= cfg_write_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		res_q  <= res_d;
		pend_q <= pend_d;
		s_q    <= s_d;
		e_q    <= e_d;
		np_q   <= np_d;
		perm_q <= perm_d;
		code_q <= code_d;
	end

	// Bank 0: written while bank 1 is live
	always_ff @(posedge clk) begin
		if (wr_en && bank_q) begin
			mem0[wr_addr] <= wr_data;
		end
		rd0_q <= mem0[rd_addr];
	end

	// Bank 1: written while bank 0 is live
	always_ff @(posedge clk) begin
		if (wr_en && !bank_q) begin
			mem1[wr_addr] <= wr_data;
		end
		rd1_q <= mem1[rd_addr];
	end

endmodule

>>> test/page_map_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the free-code port of the page region map.
// Keeps a private copy of the region table, predicts one result per
// input transfer and compares every output transfer against it.
module page_map_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  prmiq_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  prmiq_pkg::out_item_t out_data,
	input  logic                 cfg_write_en,
	input  logic [7:0]           cfg_write_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int PAGE_W     = prmiq_pkg::PAGE_W;
	localparam int PAGE_BITS  = prmiq_pkg::PAGE_BITS;
	localparam int MAX_REGIONS = prmiq_pkg::MAX_REGIONS;
	localparam int REPORT_MAX = 10;

	prmiq_pkg::region_t   rgn [MAX_REGIONS];
	int                   rgn_count;
	logic [31:0]          mapped_total;
	logic [7:0]           free_code;
	bit                   untouched;
	prmiq_pkg::region_t   pieces [MAX_REGIONS+2];
	int                   piece_cnt;
	prmiq_pkg::out_item_t owed_results [$];
	int                   miss_count;

	function automatic void add_piece(input logic [PAGE_W-1:0] first,
			input logic [PAGE_W-1:0] last, input logic [2:0] perm, input logic [7:0] code);
		if (piece_cnt < MAX_REGIONS + 2) begin
			pieces[piece_cnt] = '{first: first, last: last, perm: perm, code: code};
			piece_cnt++;
		end
	endfunction

	// Rebuild the table around the new range, merge equal neighbors, and
	// commit only if the result still fits.
	function automatic prmiq_pkg::out_item_t predict_map(input prmiq_pkg::in_item_t item);
		prmiq_pkg::region_t   joined [MAX_REGIONS+2];
		prmiq_pkg::out_item_t res;
		logic [32:0]          npages;
		logic [33:0]          end_wide;
		logic [PAGE_W-1:0]    s;
		logic [PAGE_W-1:0]    e;
		prmiq_pkg::region_t   r;
		int                   m;
		bit                   placed;
		res = '0;
		npages = (33'(item.length_bytes) + 33'((1 << PAGE_BITS) - 1)) >> PAGE_BITS;
		if (npages != 0) begin
			s = PAGE_W'(item.address >> PAGE_BITS);
			end_wide = 34'(s) + 34'(npages);
			e = (end_wide > 34'(prmiq_pkg::PAGE_COUNT)) ? prmiq_pkg::PAGE_COUNT
				: PAGE_W'(end_wide);
			piece_cnt = 0;
			placed = 0;
			for (int i = 0; i < rgn_count; i++) begin
				r = rgn[i];
				if (r.last <= s || r.first >= e) begin
					if (r.first >= e && !placed) begin
						add_piece(s, e, item.permission, item.region_state);
						placed = 1;
					end
					add_piece(r.first, r.last, r.perm, r.code);
				end else begin
					if (r.first < s)
						add_piece(r.first, s, r.perm, r.code);
					if (!placed) begin
						add_piece(s, e, item.permission, item.region_state);
						placed = 1;
					end
					if (r.last > e)
						add_piece(e, r.last, r.perm, r.code);
				end
			end
			if (!placed)
				add_piece(s, e, item.permission, item.region_state);
			m = 0;
			for (int i = 0; i < piece_cnt; i++) begin
				if (m > 0 && joined[m-1].perm == pieces[i].perm &&
						joined[m-1].code == pieces[i].code &&
						joined[m-1].last == pieces[i].first) begin
					joined[m-1].last = pieces[i].last;
				end else begin
					joined[m] = pieces[i];
					m++;
				end
			end
			if (m > MAX_REGIONS) begin
				res.status = prmiq_pkg::STATUS_FULL;
			end else begin
				for (int i = 0; i < m; i++)
					rgn[i] = joined[i];
				rgn_count = m;
				mapped_total = mapped_total + 32'(npages << PAGE_BITS);
				untouched = 0;
			end
		end
		res.mapped_bytes = mapped_total;
		return res;
	endfunction

	function automatic prmiq_pkg::out_item_t predict_query(input logic [31:0] addr);
		prmiq_pkg::out_item_t res;
		logic [PAGE_W-1:0]    page;
		bit                   hit;
		res = '0;
		page = PAGE_W'(addr >> PAGE_BITS);
		hit = 0;
		for (int i = 0; i < rgn_count; i++) begin
			if (!hit && rgn[i].first <= page && page < rgn[i].last) begin
				res.start_page = rgn[i].first;
				res.end_page = rgn[i].last;
				res.found_permission = rgn[i].perm;
				res.found_state = rgn[i].code;
				hit = 1;
			end
		end
		res.mapped_bytes = mapped_total;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		prmiq_pkg::out_item_t want;
		if (!arst_n) begin
			free_code = '0;
			rgn[0] = '{first: '0, last: prmiq_pkg::PAGE_COUNT, perm: '0, code: '0};
			rgn_count = 1;
			mapped_total = '0;
			untouched = 1;
			owed_results.delete();
			miss_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_write_en) begin
				free_code = cfg_write_data;
				if (untouched)
					rgn[0].code = free_code;
			end
			if (in_valid && !in_stall)
				owed_results.push_back(in_data.mode == prmiq_pkg::MODE_QUERY ?
					predict_query(in_data.address) : predict_map(in_data));
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					if (miss_count < REPORT_MAX)
						$display("%0t: result with no item outstanding: %h", $realtime, out_data);
					miss_count++;
				end else begin
					want = owed_results.pop_front();
					if (out_data.status !== want.status ||
							out_data.start_page !== want.start_page ||
							out_data.end_page !== want.end_page ||
							out_data.found_permission !== want.found_permission ||
							out_data.found_state !== want.found_state ||
							out_data.mapped_bytes !== want.mapped_bytes) begin
						if (miss_count < REPORT_MAX) begin
							$display("%0t: mismatch (expected/actual) status %0d/%0d start %h/%h",
								$realtime, want.status, out_data.status,
								want.start_page, out_data.start_page);
							$display("  end %h/%h perm %0d/%0d state %h/%h bytes %h/%h",
								want.end_page, out_data.end_page,
								want.found_permission, out_data.found_permission,
								want.found_state, out_data.found_state,
								want.mapped_bytes, out_data.mapped_bytes);
						end
						miss_count++;
					end
				end
			end
			mismatches <= miss_count;
			outstanding <= owed_results.size();
		end
	end

endmodule

>>> test/tb_page_region_map_insert_query.sv
`timescale 1ns / 1ps

module tb_page_region_map_insert_query;

	localparam int   ITEM_TARGET    = 1000;
	localparam int   MAX_GAP        = 10;
	localparam int   HOLDOFF_CYCLES = 300;
	localparam int   DRAIN_CYCLES   = 100;
	localparam int   PAGE_BITS      = prmiq_pkg::PAGE_BITS;
	// Allow for a full-table map, the longest gap and stall on both sides
	// plus the long receiver hold-off, then leave a wide margin.
	localparam int   STALL_LIMIT    = 20000;

	typedef enum int {MIX_BROAD, MIX_WINDOW, MIX_FILL} phase_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	prmiq_pkg::in_item_t  in_data;
	logic                 out_valid;
	logic                 out_stall;
	prmiq_pkg::out_item_t out_data;
	logic                 cfg_write_en;
	logic [7:0]           cfg_write_data;

	int          fail_count;
	int          results_owed;
	int          sent_items = 0;
	int          idle_cycles = 0;
	int          holdoff_requests = 0;
	bit          tx_gaps = 1;
	bit          rx_gaps = 1;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	page_region_map_insert_query i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	page_map_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.mismatches    (fail_count),
		.outstanding   (results_owed)
	);

	function automatic prmiq_pkg::in_item_t map_item(input logic [31:0] addr,
			input logic [31:0] len, input logic [2:0] perm, input logic [7:0] code);
		prmiq_pkg::in_item_t item;
		item.mode = prmiq_pkg::MODE_MAP;
		item.address = addr;
		item.length_bytes = len;
		item.permission = perm;
		item.region_state = code;
		return item;
	endfunction

	// The block ignores length, permission and state on a query; fill them
	// with noise so those bits still toggle.
	function automatic prmiq_pkg::in_item_t query_item(input logic [31:0] addr);
		prmiq_pkg::in_item_t item;
		item.mode = prmiq_pkg::MODE_QUERY;
		item.address = addr;
		item.length_bytes = $urandom;
		item.permission = 3'($urandom);
		item.region_state = 8'($urandom);
		return item;
	endfunction

	// Offer one item after an optional gap and hold it until the transfer.
	// With no gap, valid stays high and only the payload advances.
	task automatic put_item(input prmiq_pkg::in_item_t item);
		int gap;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	// Drop valid and wait until every result has come back. The first edge
	// lets the checker count the transfer that just happened.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_free_code(input logic [7:0] code);
		cfg_write_en <= 1'b1;
		cfg_write_data <= code;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Receiver: per result, stall a random number of cycles (none when gaps
	// are off), then accept. A hold-off request stalls for a long stretch
	// so the block fills up and pushes back on its input.
	initial begin
		int w;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (holdoff_requests > 0) begin
				holdoff_requests--;
				out_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			w = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          phase;
		int          n;
		phase_kind_t kind;
		logic [31:0] base;
		logic [31:0] len;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh table: a single free region over the whole space.
		put_item(query_item(32'h0000_0000));
		put_item(query_item(32'hFFFF_FFFF));

		// While nothing has been mapped, the free code also retags the
		// initial region; a zero-length map does not count as a map.
		settle();
		write_free_code(8'hFF);
		put_item(query_item(32'h7FFF_FFFF));
		put_item(map_item(32'hFFFF_FFFF, 32'h0000_0000, 3'd7, 8'h5A));
		settle();
		write_free_code(8'h00);
		put_item(query_item(32'h1234_5678));

		// Single byte rounds up to one page.
		put_item(map_item(32'h0000_0000, 32'h0000_0001, 3'd7, 8'hFF));
		// Largest length from the last page: end saturates, byte sum wraps.
		put_item(map_item(32'hFFFF_F000, 32'hFFFF_FFFF, 3'd5, 8'h01));
		// Unaligned base spanning two pages, then an equal neighbor to merge.
		put_item(map_item(32'h8000_0FFF, 32'h0000_1001, 3'd2, 8'h10));
		put_item(map_item(32'h8000_2000, 32'h0000_1000, 3'd2, 8'h10));
		// Split a free region, then split the new piece again.
		put_item(map_item(32'h4000_0000, 32'h0000_3000, 3'd3, 8'h33));
		put_item(map_item(32'h4000_1000, 32'h0000_1000, 3'd4, 8'h44));
		// Ends exactly where an existing region ends: no empty piece left.
		put_item(map_item(32'h4000_2000, 32'h0000_1000, 3'd4, 8'h44));
		put_item(map_item(32'h4000_0000, 32'h0000_1000, 3'd4, 8'h44));
		// Cover several regions with free attributes: merges both sides.
		put_item(map_item(32'h3FFF_F000, 32'h0000_6000, 3'd0, 8'h00));
		put_item(query_item(32'h4000_0000));
		put_item(query_item(32'h8000_0000));
		put_item(query_item(32'h8000_2FFF));
		put_item(query_item(32'h0000_0FFF));
		put_item(query_item(32'h0000_1000));
		put_item(query_item(32'hFFFF_EFFF));
		put_item(map_item(32'hFFFF_FFFF, 32'hFFFF_F001, 3'd6, 8'hC3));
		put_item(query_item(32'hFFFF_FFFF));
		// Wipe the whole space back to one region.
		put_item(map_item(32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 8'h00));
		put_item(query_item(32'h89AB_CDEF));

		// After the first map the free code no longer touches the table.
		settle();
		write_free_code(8'hFF);
		put_item(query_item(32'h0000_0000));

		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			settle();
			if ($urandom_range(0, 1))
				write_free_code(8'($urandom));
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			// Keep offering items while the receiver holds off.
			if (phase == 0 || $urandom_range(0, 7) == 0) begin
				holdoff_requests = 1;
				tx_gaps = 0;
			end
			kind = phase_kind_t'($urandom_range(0, 2));
			base = $urandom & 32'hFFF0_0000;
			case (kind)
				MIX_WINDOW: begin
					// Short maps with few attribute pairs starting inside 256 pages:
					// lots of splits and merges, and the table fills.
					n = $urandom_range(50, 90);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							put_item(query_item(base + ($urandom_range(0, 255) << PAGE_BITS)
								+ $urandom_range(0, 4095)));
						else
							put_item(map_item(base + ($urandom_range(0, 255) << PAGE_BITS)
								+ $urandom_range(0, 4095), $urandom_range(1, 3 * 4096),
								3'($urandom_range(0, 1)), 8'($urandom_range(0, 1))));
					end
				end
				MIX_FILL: begin
					// Isolated pages with distinct codes add two regions each,
					// running the table past its limit.
					for (int i = 0; i < 40; i++)
						put_item(map_item(base + ((2 * i) << PAGE_BITS) + $urandom_range(0, 4095),
							$urandom_range(1, 4096), 3'($urandom_range(1, 7)), 8'(i + 1)));
					repeat (6)
						put_item(query_item(base + ($urandom_range(0, 127) << PAGE_BITS)));
				end
				default: begin
					n = $urandom_range(20, 50);
					repeat (n) begin
						if ($urandom_range(0, 4) < 2) begin
							put_item(query_item($urandom));
						end else begin
							case ($urandom_range(0, 5))
								0: len = '0;
								1: len = $urandom;
								2: len = $urandom_range(1, 32'h4000);
								3: len = 32'hFFFF_FFFF - $urandom_range(0, 4095);
								default: len = ($urandom_range(1, 16) << PAGE_BITS)
									- $urandom_range(0, 1);
							endcase
							put_item(map_item($urandom, len, 3'($urandom),
								$urandom_range(0, 1) ? 8'($urandom_range(0, 2)) : 8'($urandom)));
						end
					end
				end
			endcase
			phase++;
		end

		// Drain, then give stray results time to show up.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
